// ----- src/tlex_pkg.sv -----
// Package for the token lexer: beat types, mode and status codes, byte classes.
// Used by token_lexer_core and tlex_checker; no dependencies.
`default_nettype none

package tlex_pkg;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] tok_char;
      logic       tok_kind;
      logic       token_end;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_COMMENT = 5'b00010,
      MODE_WORD    = 5'b00100,
      MODE_NUMBER  = 5'b01000,
      MODE_STOPPED = 5'b10000
   } mode_type;

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_EOF = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_NUMBER = 1'b1;

   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h0C, 8'h0D, 8'h09, 8'h0B};
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c inside {8'h20, CHAR_LF};
   endfunction

   function automatic logic word_class(input logic [7:0] c, input logic first);
      logic base;
      base = c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2B, 8'h2D, 8'h2A, 8'h2F,
                       8'h25, 8'h5E, 8'h7E, 8'h3C, 8'h3E, 8'h3D, 8'h21, 8'h40};
      return base || (!first && (c inside {[8'h30:8'h39]}));
   endfunction

   function automatic logic number_class(input logic [7:0] c, input logic first);
      logic base;
      base = c inside {[8'h31:8'h39], 8'h2B, 8'h2D, 8'h2E};
      return base || (!first && (c inside {8'h30, 8'h5F, 8'h65, 8'h45}));
   endfunction

endpackage

`default_nettype wire

// ----- src/token_lexer_core.sv -----
// Token lexer top level: input register, mode machine and result register.
// Depends on tlex_pkg.
// Path: an accepted req beat is held in the input reg; any rsp beat it yields goes via the result reg.
// Throughput: one byte per cycle unless rsp is stalled; the mode update is a single pass of shallow logic.
// Reset: synchronous, clears the beat valids and returns the lexer to idle mode.
`default_nettype none

module token_lexer_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tlex_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tlex_pkg::rsp_type     rsp_data
);

   logic              in_vld_ff, in_vld_in;
   tlex_pkg::req_type in_data_ff;
   tlex_pkg::mode_type mode_ff, mode_in, mode_nxt;
   logic              rsp_vld_ff, rsp_vld_in;
   tlex_pkg::rsp_type rsp_data_ff, rsp_res;
   logic              emit;
   logic              out_free;
   logic              step;
   logic              kind;
   logic [7:0]        c;
   logic              eoi;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign in_vld_in = req_valid || (in_vld_ff && !out_free);

   assign c   = in_data_ff.char_in;
   assign eoi = in_data_ff.end_of_input;

   always_comb begin
      emit     = 1'b0;
      rsp_res  = '0;
      mode_nxt = mode_ff;
      kind     = (mode_ff == tlex_pkg::MODE_NUMBER);
      case (mode_ff)
         tlex_pkg::MODE_IDLE: begin
            if (eoi) begin
               mode_nxt       = tlex_pkg::MODE_STOPPED;
               emit           = 1'b1;
               rsp_res.status = tlex_pkg::ST_EOF;
            end else if (c == tlex_pkg::CHAR_HASH) begin
               mode_nxt = tlex_pkg::MODE_COMMENT;
            end else if (tlex_pkg::word_class(c, 1'b1)) begin
               mode_nxt         = tlex_pkg::MODE_WORD;
               emit             = 1'b1;
               rsp_res.tok_char = c;
               rsp_res.tok_kind = tlex_pkg::KIND_WORD;
            end else if (tlex_pkg::number_class(c, 1'b1)) begin
               mode_nxt         = tlex_pkg::MODE_NUMBER;
               emit             = 1'b1;
               rsp_res.tok_char = c;
               rsp_res.tok_kind = tlex_pkg::KIND_NUMBER;
            end else if (!(tlex_pkg::is_space(c) || tlex_pkg::is_sep(c))) begin
               mode_nxt       = tlex_pkg::MODE_STOPPED;
               emit           = 1'b1;
               rsp_res.status = tlex_pkg::ST_BAD;
            end
         end
         tlex_pkg::MODE_COMMENT: begin
            if (eoi) begin
               mode_nxt       = tlex_pkg::MODE_STOPPED;
               emit           = 1'b1;
               rsp_res.status = tlex_pkg::ST_EOF;
            end else if (c == tlex_pkg::CHAR_LF) begin
               mode_nxt = tlex_pkg::MODE_IDLE;
            end
         end
         tlex_pkg::MODE_WORD, tlex_pkg::MODE_NUMBER: begin
            emit             = 1'b1;
            rsp_res.tok_kind = kind;
            if (eoi) begin
               mode_nxt          = tlex_pkg::MODE_STOPPED;
               rsp_res.token_end = 1'b1;
               rsp_res.status    = tlex_pkg::ST_EOF;
            end else if (kind ? tlex_pkg::number_class(c, 1'b0)
                              : tlex_pkg::word_class(c, 1'b0)) begin
               rsp_res.tok_char = c;
            end else if (tlex_pkg::is_space(c) || tlex_pkg::is_sep(c)) begin
               mode_nxt          = tlex_pkg::MODE_IDLE;
               rsp_res.token_end = 1'b1;
            end else begin
               mode_nxt       = tlex_pkg::MODE_STOPPED;
               rsp_res.status = tlex_pkg::ST_BAD;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign mode_in    = step ? mode_nxt : mode_ff;
   assign rsp_vld_in = out_free ? (step && emit) : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mode_ff    <= tlex_pkg::MODE_IDLE;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (step && emit) begin
         rsp_data_ff <= rsp_res;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/tlex_checker.sv -----
// Port-level checks for token_lexer_core, bound to the top level.
// Depends on tlex_pkg and token_lexer_core.
`default_nettype none

module tlex_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tlex_pkg::rsp_type rsp_data
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // nothing comes out after a stop beat is taken
   a_quiet_after_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.status != tlex_pkg::ST_RUN |=> !rsp_valid)
      else $error("rsp beat after stop");

   // stop and token-end beats carry no byte
   a_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != tlex_pkg::ST_RUN || rsp_data.token_end)
      |-> rsp_data.tok_char == 8'd0)
      else $error("byte on stop or token-end beat");

   // every beat carries a legal status, and a running data beat a real byte
   a_run_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= tlex_pkg::ST_BAD &&
      (rsp_data.status != tlex_pkg::ST_RUN || rsp_data.token_end ||
       rsp_data.tok_char != 8'd0))
      else $error("bad running beat");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind token_lexer_core tlex_checker u_tlex_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
